FILE: design/kmsd_pkg.sv
// Shared types, constants and the pin-to-column remap for the key matrix
// scan and debounce block. No dependencies.
package kmsd_pkg;

    localparam int COLS         = 18;
    localparam int IDX_W        = 3;
    localparam int PIN_W        = 16;
    localparam int CNT_W        = 8;
    localparam int ROWS_DEFAULT = 7;

    typedef logic [COLS-1:0]  t_cols;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [PIN_W-1:0] t_pins;

    localparam t_cnt DEBOUNCE_RESET = t_cnt'(4);

    // One registered row reading, already remapped to columns.
    typedef struct packed {
        t_idx  row_index;
        t_cols cols;
        logic  last_row;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_cols stable_row;
        logic  bounce;
        logic  committed;
        t_cnt  settle_left;
    } t_result;

    // Invert active-low pins: B0,B1 -> 0,1; B3..B15 -> 2..14; A7,A8,A15 -> 15..17.
    function automatic t_cols gather_columns(input t_pins pa, input t_pins pb);
        t_pins a;
        t_pins b;
        a = ~pa;
        b = ~pb;
        return {a[15], a[8], a[7], b[15:3], b[1:0]};
    endfunction

endpackage

FILE: design/kmsd_in_stage.sv
// Input register for one row reading; remaps pins to columns on capture.
// Depends on kmsd_pkg.
module kmsd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  kmsd_pkg::t_idx  i_row_index,
    input  kmsd_pkg::t_pins i_port_a_pins,
    input  kmsd_pkg::t_pins i_port_b_pins,
    input  logic           i_last_row,
    input  logic           i_advance,
    output logic           o_stall,
    output logic           o_full,
    output kmsd_pkg::t_item o_item
);
    import kmsd_pkg::*;

    logic  r_full;
    logic  n_full;
    t_item r_item;
    logic  load;

    assign o_stall = r_full && !i_advance;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_full = r_full;
        if (load) begin
            n_full = 1'b1;
        end else if (i_advance) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.row_index <= i_row_index;
            r_item.cols      <= gather_columns(i_port_a_pins, i_port_b_pins);
            r_item.last_row  <= i_last_row;
        end
    end

    assign o_full = r_full;
    assign o_item = r_item;

endmodule

FILE: design/kmsd_update.sv
// Row state (pending and stable rows), settle counter and debounce register,
// plus the one-pass update for a row reading. Depends on kmsd_pkg.
module kmsd_update #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  kmsd_pkg::t_cnt    i_cfg_data,
    input  logic              i_fire,
    input  kmsd_pkg::t_item   i_item,
    output kmsd_pkg::t_result o_result
);
    import kmsd_pkg::*;

    t_cols r_pending [ROWS];
    t_cols r_stable  [ROWS];
    t_cols n_pending [ROWS];
    t_cols n_stable  [ROWS];
    t_cnt  r_settle;
    t_cnt  n_settle;
    t_cnt  r_dbc;
    t_cnt  cnt_a;
    logic  [ROWS-1:0] hit;
    logic  changed;
    logic  dec;
    logic  commit;
    t_cols row_out;

    always_comb begin
        changed = 1'b0;
        for (int i = 0; i < ROWS; i++) begin
            hit[i] = (int'(i_item.row_index) == i);
            if (hit[i] && (r_pending[i] != i_item.cols)) begin
                changed = 1'b1;
            end
        end

        cnt_a    = changed ? r_dbc : r_settle;
        dec      = i_item.last_row && (cnt_a != '0);
        n_settle = dec ? cnt_a - t_cnt'(1) : cnt_a;
        commit   = dec && (n_settle == '0);

        row_out = '0;
        for (int i = 0; i < ROWS; i++) begin
            n_pending[i] = hit[i] ? i_item.cols : r_pending[i];
            n_stable[i]  = commit ? n_pending[i] : r_stable[i];
            if (hit[i]) begin
                row_out = n_stable[i];
            end
        end

        o_result.stable_row  = row_out;
        o_result.bounce      = changed && (r_settle != '0);
        o_result.committed   = commit;
        o_result.settle_left = n_settle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_pending[i] <= '0;
                r_stable[i]  <= '0;
            end
            r_settle <= DEBOUNCE_RESET;
        end else if (i_fire) begin
            for (int i = 0; i < ROWS; i++) begin
                r_pending[i] <= n_pending[i];
                r_stable[i]  <= n_stable[i];
            end
            r_settle <= n_settle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbc <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_dbc <= i_cfg_data;
        end
    end

endmodule

FILE: design/kmsd_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
// Depends on kmsd_pkg.
module kmsd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_full,
    input  kmsd_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_advance,
    output logic              o_valid,
    output kmsd_pkg::t_result o_result
);
    import kmsd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;
    assign n_valid   = o_advance ? i_full : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_full) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/key_matrix_scan_debounce.sv
// Top level of the key matrix row reader with one global debounce counter.
// Depends on kmsd_pkg, kmsd_in_stage, kmsd_update and kmsd_out_stage.
//
// Usage:
//   Input channel: one beat per matrix row reading (row index, raw active-low
//   port A and port B words, last-row-of-scan flag), taken at an edge with
//   i_in_valid high and o_in_stall low.
//   Output channel: one result beat per input beat (stable row of the
//   indexed row, bounce, committed, settle counter), taken at an edge with
//   o_out_valid high and i_out_stall low. Results keep input order.
//   Config channel: i_cfg_valid / o_cfg_ready write debounce_count; ready
//   is always high. Write only while no beat is in flight.
//   Path: a beat is captured in the input register, then the row update
//   feeds the result register, where the receiver takes it.
//   Throughput: one beat per cycle when i_out_stall is low; the row state
//   update is one combinational pass, so each beat sees the last beat's state.
//   Stall: while the result register is held, the input register holds its
//   beat and o_in_stall rises once that register is occupied as well.
//   Reset: synchronous, active low. All rows clear to zero, the settle
//   counter and debounce_count return to 4, both registers empty.
module key_matrix_scan_debounce #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input beats
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [kmsd_pkg::IDX_W-1:0]  i_row_index,
    input  logic [kmsd_pkg::PIN_W-1:0]  i_port_a_pins,
    input  logic [kmsd_pkg::PIN_W-1:0]  i_port_b_pins,
    input  logic                        i_last_row,
    // result beats
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [kmsd_pkg::COLS-1:0]   o_stable_row,
    output logic                        o_bounce,
    output logic                        o_committed,
    output logic [kmsd_pkg::CNT_W-1:0]  o_settle_left,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kmsd_pkg::CNT_W-1:0]  i_cfg_data
);
    import kmsd_pkg::*;

    t_item   item;
    t_result upd_result;
    t_result out_result;
    logic    in_full;
    logic    advance;

    // Config always ready; user must write only while pipe is idle; unchecked.
    assign o_cfg_ready = 1'b1;

    // Stage 1: capture the reading and remap pins to columns.
    kmsd_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_row_index   (i_row_index),
        .i_port_a_pins (i_port_a_pins),
        .i_port_b_pins (i_port_b_pins),
        .i_last_row    (i_last_row),
        .i_advance     (advance),
        .o_stall       (o_in_stall),
        .o_full        (in_full),
        .o_item        (item)
    );

    // Stage 2: update pending/stable rows and the counter as the beat moves on.
    kmsd_update #(
        .ROWS (ROWS)
    ) u_upd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_fire     (in_full && advance),
        .i_item     (item),
        .o_result   (upd_result)
    );

    // Result register: hold the beat while the receiver stalls.
    kmsd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_full    (in_full),
        .i_result  (upd_result),
        .i_stall   (i_out_stall),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .o_result  (out_result)
    );

    assign o_stable_row  = out_result.stable_row;
    assign o_bounce      = out_result.bounce;
    assign o_committed   = out_result.committed;
    assign o_settle_left = out_result.settle_left;

endmodule

FILE: design/kmsd_checker.sv
// Port-level checks for key_matrix_scan_debounce, attached by bind.
// Depends on kmsd_pkg.
module kmsd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [kmsd_pkg::COLS-1:0]   o_stable_row,
    input logic                        o_committed,
    input logic [kmsd_pkg::CNT_W-1:0]  o_settle_left
);
    import kmsd_pkg::*;

    // A commit only happens when the counter reaches zero.
    a_commit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_committed) |-> (o_settle_left == '0))
        else $error("commit with nonzero settle counter");

    // An empty result register never back-pressures the input.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while result register empty");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_stable_row) && $stable(o_settle_left)))
        else $error("stalled result beat changed");

endmodule

bind key_matrix_scan_debounce kmsd_checker u_kmsd_checker (.*);
